### rtl/thfe_pkg.sv
// shared types and constants for the tls hello field extractor
package thfe_pkg;

  localparam logic [7:0] CT_HANDSHAKE = 8'd22;
  localparam logic [7:0] HS_CLIENT = 8'd1;
  localparam logic [7:0] HS_SERVER = 8'd2;
  localparam logic [15:0] EXT_SNI = 16'h0000;
  localparam logic [15:0] EXT_ALPN = 16'h0010;
  localparam logic [15:0] EXT_SV = 16'h002B;
  localparam logic [15:0] HS_FIXED_LEN = 16'd37;

  typedef enum logic [3:0] {
    K_DONE = 4'd0, K_CIPHER = 4'd1, K_SNI_START = 4'd2, K_SNI_BYTE = 4'd3,
    K_ALPN_LIST = 4'd4, K_ALPN_PSTART = 4'd5, K_ALPN_BYTE = 4'd6,
    K_VERSION = 4'd7, K_TRUNC = 4'd8
  } kind_t;

  typedef enum logic [25:0] {
    P_H0        = 26'h0000001,
    P_H1        = 26'h0000002,
    P_H2        = 26'h0000004,
    P_H3        = 26'h0000008,
    P_H4        = 26'h0000010,
    P_SKIP      = 26'h0000020,
    P_HSTYPE    = 26'h0000040,
    P_HSFIXED   = 26'h0000080,
    P_SIDLEN    = 26'h0000100,
    P_SIDSKIP   = 26'h0000200,
    P_CSLEN     = 26'h0000400,
    P_CSBODY    = 26'h0000800,
    P_COMPLEN   = 26'h0001000,
    P_COMPSKIP  = 26'h0002000,
    P_SRVSUITE  = 26'h0004000,
    P_SRVCOMP   = 26'h0008000,
    P_EXTTOTAL  = 26'h0010000,
    P_EXTHDR    = 26'h0020000,
    P_EXTSKIP   = 26'h0040000,
    P_SNIPRE    = 26'h0080000,
    P_SNINAME   = 26'h0100000,
    P_ALPNLIST  = 26'h0200000,
    P_ALPNPLEN  = 26'h0400000,
    P_ALPNPROTO = 26'h0800000,
    P_SVCLIENT  = 26'h1000000,
    P_SVSERVER  = 26'h2000000
  } phase_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] value;
    logic [15:0] extra;
    logic [7:0]  content_type;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } item_t;

endpackage

### rtl/thfe_if.sv
// valid/ready channel interfaces for input bytes and results
interface thfe_in_if;
  import thfe_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface thfe_out_if;
  import thfe_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/thfe_out_queue.sv
// small result queue that takes up to three results per byte and drains them one per cycle while out.ready is high
module thfe_out_queue
  import thfe_pkg::*;
#(
  parameter int Depth = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_n,
  input  result_t       push_d [3],
  output logic          room,
  thfe_out_if.source    out
);
  localparam int AW = $clog2(Depth);
  result_t mem [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r, cnt_nxt;
  logic pop;

  assign pop = out.valid && out.ready;
  assign out.valid = (cnt_r != '0);
  assign out.data = mem[rp_r];
  assign room = ({1'b0, cnt_r} + (AW+2)'(3)) <= (AW+2)'(Depth);
  assign cnt_nxt = cnt_r + (AW+1)'(push_n) - (AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push_n > 2'd0) mem[wp_r] <= push_d[0];
    if (push_n > 2'd1) mem[wp_r + AW'(1)] <= push_d[1];
    if (push_n > 2'd2) mem[wp_r + AW'(2)] <= push_d[2];
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_r + AW'(push_n);
      rp_r <= rp_r + AW'(pop);
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(Depth)) else $error("queue overflow");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !out.valid) else $error("valid while empty");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n == 2'd0 && !pop) |=> $stable(cnt_r)) else $error("count moved");
`endif
endmodule

### rtl/tls_hello_field_extractor_unit.sv
// top level: tls record parser with hello field extraction
// a byte is registered at input; its results enter the queue when the queue has room
// throughput: one byte per cycle; up to three results per byte drain at one per cycle,
//   so ready drops while a byte is held and the eight-entry queue lacks room for three
// reset: synchronous active-low rst_n returns the parser to record header byte zero
//   and empties the result queue
module tls_hello_field_extractor_unit
  import thfe_pkg::*;
#(
  parameter int QDepth = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  thfe_in_if.sink    in_ch,
  thfe_out_if.source out_ch
);
  // input register stage
  logic   iv_r;
  item_t  id_r;
  logic   room;
  logic   take;

  // parser state
  phase_t ph_r, ph;
  logic [7:0]  rtype_r, rtype, hb_r, hb, pidx_r, pidx;
  logic        cli_r, cli;
  logic [15:0] rver_r, rver, rlen_r, rlen, seen_r, seen, fc_r, fc, fl_r, fl;
  logic [15:0] xend_r, xend, xt_r, xt, xl_r, xl, ic_r, ic, bv_r, bv;

  result_t res [3];
  logic [1:0] n;

  // ready while the stage is free or drains this cycle into the queue
  assign in_ch.ready = !iv_r || room;
  assign take = in_ch.valid && in_ch.ready;

  always_comb begin
    logic [7:0]  b;
    logic [15:0] w, k, off;
    logic [16:0] room17, e17;
    logic        done;
    b = id_r.data_byte;
    w = {hb_r, b};
    ph = ph_r; rtype = rtype_r; hb = hb_r; pidx = pidx_r; cli = cli_r;
    rver = rver_r; rlen = rlen_r; seen = seen_r; fc = fc_r; fl = fl_r;
    xend = xend_r; xt = xt_r; xl = xl_r; ic = ic_r; bv = bv_r;
    n = 2'd0;
    done = 1'b0;
    k = '0; off = '0; room17 = '0; e17 = '0;
    for (int i = 0; i < 3; i++) res[i] = '0;

    case (ph_r)
      P_H0: begin
        rtype = b; rver = '0; rlen = '0; seen = '0; ph = P_H1;
      end
      P_H1: begin rver = {b, 8'h00}; ph = P_H2; end
      P_H2: begin rver = {rver_r[15:8], b}; ph = P_H3; end
      P_H3: begin rlen = {b, 8'h00}; ph = P_H4; end
      P_H4: begin
        rlen = {rlen_r[15:8], b};
        if (rlen == '0) done = 1'b1;
        else ph = (rtype_r == CT_HANDSHAKE) ? P_HSTYPE : P_SKIP;
      end
      default: begin
        seen = seen_r + 16'd1;
        room17 = {1'b0, rlen_r} - {1'b0, seen};
        case (ph_r)
          P_SKIP: ;
          P_HSTYPE: begin
            if (b == HS_CLIENT || b == HS_SERVER) begin
              cli = (b == HS_CLIENT); fc = '0; ph = P_HSFIXED;
            end else ph = P_SKIP;
          end
          P_HSFIXED: begin
            fc = fc_r + 16'd1;
            if (fc >= HS_FIXED_LEN) ph = P_SIDLEN;
          end
          P_SIDLEN, P_SIDSKIP: begin
            if (ph_r == P_SIDLEN) begin fl = {8'h00, b}; fc = '0; end
            else fc = fc_r + 16'd1;
            if (fc >= fl) begin
              fc = '0; ph = cli_r ? P_CSLEN : P_SRVSUITE;
            end else ph = P_SIDSKIP;
          end
          P_CSLEN: begin
            if (fc_r == '0) begin hb = b; fc = 16'd1; end
            else begin
              fl = w; fc = '0;
              // cipher list must fit inside the record
              if ({1'b0, w} > room17) ph = P_SKIP;
              else ph = (w != '0) ? P_CSBODY : P_COMPLEN;
            end
          end
          P_CSBODY: begin
            fc = fc_r + 16'd1;
            if (fc[0]) hb = b;
            else begin res[n] = '{K_CIPHER, w, 16'h0, 8'h0, 1'b0}; n = n + 2'd1; end
            if (fc >= fl_r) ph = P_COMPLEN;
          end
          P_COMPLEN, P_COMPSKIP: begin
            if (ph_r == P_COMPLEN) begin fl = {8'h00, b}; fc = '0; end
            else fc = fc_r + 16'd1;
            if (fc >= fl) begin fc = '0; ph = P_EXTTOTAL; end
            else ph = P_COMPSKIP;
          end
          P_SRVSUITE: begin
            if (fc_r == '0) begin hb = b; fc = 16'd1; end
            else begin
              res[n] = '{K_CIPHER, w, 16'h0, 8'h0, 1'b0}; n = n + 2'd1;
              ph = P_SRVCOMP;
            end
          end
          P_SRVCOMP: begin fc = '0; ph = P_EXTTOTAL; end
          P_EXTTOTAL: begin
            if (fc_r == '0) begin hb = b; fc = 16'd1; end
            else begin
              // extensions block clipped to record end
              e17 = {1'b0, seen} + {1'b0, w};
              xend = (e17 > {1'b0, rlen_r}) ? rlen_r : e17[15:0];
              if (xend >= seen && (xend - seen) >= 16'd4) begin
                ph = P_EXTHDR; fc = '0;
              end else ph = P_SKIP;
            end
          end
          P_EXTHDR: begin
            if (fc_r == 16'd0 || fc_r == 16'd2) begin hb = b; fc = fc_r + 16'd1; end
            else if (fc_r == 16'd1) begin xt = w; fc = fc_r + 16'd1; end
            else begin
              xl = w;
              if ({1'b0, seen} + {1'b0, w} > {1'b0, xend_r}) ph = P_SKIP;
              else begin
                ic = '0;
                if (w == '0) begin
                  if (xend_r >= seen && (xend_r - seen) >= 16'd4) begin
                    ph = P_EXTHDR; fc = '0;
                  end else ph = P_SKIP;
                end else begin
                  ph = P_EXTSKIP;
                  if (xt_r == EXT_SNI) begin
                    if (w >= 16'd5) ph = P_SNIPRE;
                  end else if (xt_r == EXT_ALPN) begin
                    if (w >= 16'd2) ph = P_ALPNLIST;
                  end else if (xt_r == EXT_SV) begin
                    if (cli_r) begin if (w >= 16'd3) ph = P_SVCLIENT; end
                    else if (w >= 16'd2) ph = P_SVSERVER;
                  end
                end
              end
            end
          end
          P_EXTSKIP, P_SNIPRE, P_SNINAME, P_ALPNLIST, P_ALPNPLEN, P_ALPNPROTO,
          P_SVCLIENT, P_SVSERVER: begin
            ic = ic_r + 16'd1;
            k = ic;
            case (ph_r)
              P_SNIPRE: begin
                if (k == 16'd4) hb = b;
                else if (k == 16'd5) begin
                  if ({1'b0, w} + 17'd5 <= {1'b0, xl_r}) begin
                    res[n] = '{K_SNI_START, w, 16'h0, 8'h0, 1'b0}; n = n + 2'd1;
                    fl = w; fc = '0;
                    ph = (w != '0) ? P_SNINAME : P_EXTSKIP;
                  end else ph = P_EXTSKIP;
                end
              end
              P_SNINAME: begin
                res[n] = '{K_SNI_BYTE, {8'h00, b}, fc_r, 8'h0, 1'b0}; n = n + 2'd1;
                fc = fc_r + 16'd1;
                if (fc >= fl_r) ph = P_EXTSKIP;
              end
              P_ALPNLIST: begin
                if (k == 16'd1) hb = b;
                else begin
                  res[n] = '{K_ALPN_LIST, w, 16'h0, 8'h0, 1'b0}; n = n + 2'd1;
                  pidx = '0; ph = P_ALPNPLEN;
                end
              end
              P_ALPNPLEN: begin
                if ({1'b0, k} + 17'(b) <= {1'b0, xl_r}) begin
                  res[n] = '{K_ALPN_PSTART, {8'h00, b}, {8'h00, pidx_r}, 8'h0, 1'b0};
                  n = n + 2'd1;
                  if (b == 8'h00) pidx = pidx_r + 8'd1;
                  else begin fl = {8'h00, b}; fc = '0; ph = P_ALPNPROTO; end
                end else ph = P_EXTSKIP;
              end
              P_ALPNPROTO: begin
                res[n] = '{K_ALPN_BYTE, {8'h00, b}, {8'h00, pidx_r}, 8'h0, 1'b0};
                n = n + 2'd1;
                fc = fc_r + 16'd1;
                if (fc >= fl_r) begin pidx = pidx_r + 8'd1; ph = P_ALPNPLEN; end
              end
              P_SVCLIENT: begin
                off = k - 16'd1;
                if (off == '0) begin fl = {8'h00, b}; bv = '0; end
                else if (off[0]) hb = b;
                else if (off <= fl_r) begin
                  if (w > bv_r) bv = w;
                end
              end
              P_SVSERVER: begin
                if (k == 16'd1) hb = b;
                else begin
                  res[n] = '{K_VERSION, w, 16'h0, 8'h0, 1'b0}; n = n + 2'd1;
                  ph = P_EXTSKIP;
                end
              end
              default: ;
            endcase
            if (ic >= xl_r) begin
              if (ph == P_SVCLIENT && bv != '0) begin
                res[n] = '{K_VERSION, bv, 16'h0, 8'h0, 1'b0}; n = n + 2'd1;
              end
              if (xend_r >= seen && (xend_r - seen) >= 16'd4) begin
                ph = P_EXTHDR; fc = '0;
              end else ph = P_SKIP;
            end
          end
          default: ph = P_SKIP;
        endcase
        if (seen >= rlen_r) done = 1'b1;
      end
    endcase

    if (done) begin
      res[n] = '{K_DONE, rver, rlen, rtype, 1'b0}; n = n + 2'd1; ph = P_H0;
    end else if (id_r.buffer_end) begin
      res[n] = '{K_TRUNC, rver, rlen, rtype, 1'b0}; n = n + 2'd1; ph = P_H0;
    end
    if (n != 2'd0) res[n - 2'd1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (take) id_r <= in_ch.data;
    if (!rst_n) begin
      iv_r <= 1'b0;
      ph_r <= P_H0;
      rtype_r <= '0; hb_r <= '0; pidx_r <= '0; cli_r <= 1'b0;
      rver_r <= '0; rlen_r <= '0; seen_r <= '0; fc_r <= '0; fl_r <= '0;
      xend_r <= '0; xt_r <= '0; xl_r <= '0; ic_r <= '0; bv_r <= '0;
    end else begin
      if (take) iv_r <= 1'b1;
      else if (room) iv_r <= 1'b0;
      // state advances when the registered byte moves into the queue
      if (iv_r && room) begin
        ph_r <= ph; rtype_r <= rtype; hb_r <= hb; pidx_r <= pidx; cli_r <= cli;
        rver_r <= rver; rlen_r <= rlen; seen_r <= seen; fc_r <= fc; fl_r <= fl;
        xend_r <= xend; xt_r <= xt; xl_r <= xl; ic_r <= ic; bv_r <= bv;
      end
    end
  end

  thfe_out_queue #(.Depth(QDepth)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_n ((iv_r && room) ? n : 2'd0),
    .push_d (res),
    .room   (room),
    .out    (out_ch)
  );

`ifndef SYNTHESIS
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    (iv_r && room && id_r.buffer_end) |=> (ph_r == P_H0))
    else $error("buffer end did not return to header");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (iv_r && !room) |=> (iv_r && $stable(ph_r))) else $error("stage lost byte");
  a_header_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (iv_r && room && ph_r == P_H0) |=> (seen_r == '0)) else $error("count not cleared");
`endif
endmodule

### bench/tls_hello_field_extractor_unit_tb.sv
// testbench for the tls hello field extractor: directed and random record streams
`timescale 1ns / 1ps

module tls_hello_field_extractor_unit_tb;
  import thfe_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  thfe_in_if in_ch ();
  thfe_out_if out_ch ();

  tls_hello_field_extractor_unit u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // parser state mirrored from the block's behaviour
  phase_t      ph;
  logic [7:0]  rec_type, hbyte, proto_idx;
  logic        is_client;
  logic [15:0] rec_ver, rec_len, rec_seen, fcnt, flen, ext_end, ext_type, ext_len;
  logic [15:0] icnt, best_ver;

  result_t step_res[$];
  result_t results_due[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int records_sent = 0;

  function automatic void put_byte(ref logic [7:0] q[$], input logic [7:0] b);
    q.insert(q.size(), b);
  endfunction

  function automatic void add_res(logic [3:0] k, logic [15:0] v, logic [15:0] x,
                                  logic [7:0] ct);
    result_t r;
    if (step_res.size() >= 3) return;
    r.kind = k;
    r.value = v;
    r.extra = x;
    r.content_type = ct;
    r.last = 1'b0;
    step_res.insert(step_res.size(), r);
  endfunction

  function automatic void next_extension();
    if (ext_end >= rec_seen && (ext_end - rec_seen) >= 16'd4) begin
      ph = P_EXTHDR;
      fcnt = 0;
    end else begin
      ph = P_SKIP;
    end
  endfunction

  function automatic void open_extension();
    icnt = 0;
    if (ext_len == 0) begin
      next_extension();
      return;
    end
    ph = P_EXTSKIP;
    if (ext_type == EXT_SNI) begin
      if (ext_len >= 5) ph = P_SNIPRE;
    end else if (ext_type == EXT_ALPN) begin
      if (ext_len >= 2) ph = P_ALPNLIST;
    end else if (ext_type == EXT_SV) begin
      if (is_client) begin
        if (ext_len >= 3) ph = P_SVCLIENT;
      end else if (ext_len >= 2) begin
        ph = P_SVSERVER;
      end
    end
  endfunction

  function automatic void extension_byte(logic [7:0] b);
    logic [15:0] k, nl, off, v;
    k = icnt;
    case (ph)
      P_SNIPRE: begin
        if (k == 4) hbyte = b;
        else if (k == 5) begin
          nl = {hbyte, b};
          if (17'd5 + nl <= {1'b0, ext_len}) begin
            add_res(K_SNI_START, nl, 0, 0);
            flen = nl;
            fcnt = 0;
            ph = (nl != 0) ? P_SNINAME : P_EXTSKIP;
          end else begin
            ph = P_EXTSKIP;
          end
        end
      end
      P_SNINAME: begin
        add_res(K_SNI_BYTE, {8'd0, b}, fcnt, 0);
        fcnt++;
        if (fcnt >= flen) ph = P_EXTSKIP;
      end
      P_ALPNLIST: begin
        if (k == 1) hbyte = b;
        else begin
          add_res(K_ALPN_LIST, {hbyte, b}, 0, 0);
          proto_idx = 0;
          ph = P_ALPNPLEN;
        end
      end
      P_ALPNPLEN: begin
        if (17'(k) + b <= {1'b0, ext_len}) begin
          add_res(K_ALPN_PSTART, {8'd0, b}, {8'd0, proto_idx}, 0);
          if (b == 0) proto_idx++;
          else begin
            flen = {8'd0, b};
            fcnt = 0;
            ph = P_ALPNPROTO;
          end
        end else begin
          ph = P_EXTSKIP;
        end
      end
      P_ALPNPROTO: begin
        add_res(K_ALPN_BYTE, {8'd0, b}, {8'd0, proto_idx}, 0);
        fcnt++;
        if (fcnt >= flen) begin
          proto_idx++;
          ph = P_ALPNPLEN;
        end
      end
      P_SVCLIENT: begin
        off = k - 16'd1;
        if (off == 0) begin
          flen = {8'd0, b};
          best_ver = 0;
        end else if (off[0]) hbyte = b;
        else if (off <= flen) begin
          v = {hbyte, b};
          if (v > best_ver) best_ver = v;
        end
      end
      P_SVSERVER: begin
        if (k == 1) hbyte = b;
        else begin
          add_res(K_VERSION, {hbyte, b}, 0, 0);
          ph = P_EXTSKIP;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void record_body_byte(logic [7:0] b);
    logic [16:0] room, e;
    room = {1'b0, rec_len} - rec_seen;
    case (ph)
      P_HSTYPE: begin
        if (b == HS_CLIENT || b == HS_SERVER) begin
          is_client = (b == HS_CLIENT);
          fcnt = 0;
          ph = P_HSFIXED;
        end else ph = P_SKIP;
      end
      P_HSFIXED: begin
        fcnt++;
        if (fcnt >= HS_FIXED_LEN) ph = P_SIDLEN;
      end
      P_SIDLEN, P_SIDSKIP: begin
        if (ph == P_SIDLEN) begin
          flen = {8'd0, b};
          fcnt = 0;
        end else fcnt++;
        if (fcnt >= flen) begin
          fcnt = 0;
          ph = is_client ? P_CSLEN : P_SRVSUITE;
        end else ph = P_SIDSKIP;
      end
      P_CSLEN: begin
        if (fcnt == 0) begin
          hbyte = b;
          fcnt = 1;
        end else begin
          flen = {hbyte, b};
          fcnt = 0;
          if ({1'b0, flen} > room) ph = P_SKIP;
          else ph = (flen != 0) ? P_CSBODY : P_COMPLEN;
        end
      end
      P_CSBODY: begin
        fcnt++;
        if (fcnt[0]) hbyte = b;
        else add_res(K_CIPHER, {hbyte, b}, 0, 0);
        if (fcnt >= flen) ph = P_COMPLEN;
      end
      P_COMPLEN, P_COMPSKIP: begin
        if (ph == P_COMPLEN) begin
          flen = {8'd0, b};
          fcnt = 0;
        end else fcnt++;
        if (fcnt >= flen) begin
          fcnt = 0;
          ph = P_EXTTOTAL;
        end else ph = P_COMPSKIP;
      end
      P_SRVSUITE: begin
        if (fcnt == 0) begin
          hbyte = b;
          fcnt = 1;
        end else begin
          add_res(K_CIPHER, {hbyte, b}, 0, 0);
          ph = P_SRVCOMP;
        end
      end
      P_SRVCOMP: begin
        fcnt = 0;
        ph = P_EXTTOTAL;
      end
      P_EXTTOTAL: begin
        if (fcnt == 0) begin
          hbyte = b;
          fcnt = 1;
        end else begin
          // extensions block clipped to the record end
          e = {1'b0, rec_seen} + {hbyte, b};
          if (e > {1'b0, rec_len}) e = {1'b0, rec_len};
          ext_end = e[15:0];
          next_extension();
        end
      end
      P_EXTHDR: begin
        if (fcnt == 0 || fcnt == 2) begin
          hbyte = b;
          fcnt++;
        end else if (fcnt == 1) begin
          ext_type = {hbyte, b};
          fcnt++;
        end else begin
          ext_len = {hbyte, b};
          if ({1'b0, rec_seen} + ext_len > {1'b0, ext_end}) ph = P_SKIP;
          else open_extension();
        end
      end
      P_EXTSKIP, P_SNIPRE, P_SNINAME, P_ALPNLIST, P_ALPNPLEN, P_ALPNPROTO,
      P_SVCLIENT, P_SVSERVER: begin
        icnt++;
        extension_byte(b);
        if (icnt >= ext_len) begin
          if (ph == P_SVCLIENT && best_ver > 0) add_res(K_VERSION, best_ver, 0, 0);
          next_extension();
        end
      end
      default: ph = P_SKIP;
    endcase
  endfunction

  // works out the results of one byte and queues them
  function automatic void predict_byte(logic [7:0] b, logic bend);
    logic done;
    done = 1'b0;
    step_res.delete();
    case (ph)
      P_H0: begin
        rec_type = b;
        rec_ver = 0;
        rec_len = 0;
        rec_seen = 0;
        ph = P_H1;
      end
      P_H1: begin rec_ver = {b, 8'd0}; ph = P_H2; end
      P_H2: begin rec_ver[7:0] = b; ph = P_H3; end
      P_H3: begin rec_len = {b, 8'd0}; ph = P_H4; end
      P_H4: begin
        rec_len[7:0] = b;
        if (rec_len == 0) done = 1'b1;
        else ph = (rec_type == CT_HANDSHAKE) ? P_HSTYPE : P_SKIP;
      end
      default: begin
        rec_seen++;
        record_body_byte(b);
        if (rec_seen >= rec_len) done = 1'b1;
      end
    endcase
    if (done) begin
      add_res(K_DONE, rec_ver, rec_len, rec_type);
      ph = P_H0;
    end else if (bend) begin
      add_res(K_TRUNC, rec_ver, rec_len, rec_type);
      ph = P_H0;
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) results_due.insert(results_due.size(), step_res[i]);
  endfunction

  // one byte transfer, predicted on acceptance
  task automatic send_byte(logic [7:0] b, logic bend);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data.data_byte <= b;
    in_ch.data.buffer_end <= bend;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_byte(b, bend);
    bytes_sent++;
  endtask

  task automatic send_buf(input logic [7:0] buf_q[$], input logic cut);
    foreach (buf_q[i]) send_byte(buf_q[i], cut && (i == buf_q.size() - 1));
  endtask

  // builds one hello record; content is randomised in the shapes the parser walks
  function automatic void build_hello(ref logic [7:0] q[$], input logic client,
                                      input int n_suites, input logic odd_cs,
                                      input int sni_len, input int alpn_n,
                                      input int sv_n, input logic bad_len);
    logic [7:0] body[$];
    logic [7:0] ext[$];
    int cs_len, ln, el, pl;
    put_byte(body, client ? HS_CLIENT : HS_SERVER);
    repeat (37) put_byte(body, 8'($urandom));
    ln = $urandom_range(3);
    put_byte(body, 8'(ln));
    repeat (ln) put_byte(body, 8'($urandom));
    if (client) begin
      cs_len = 2 * n_suites + (odd_cs ? 1 : 0);
      put_byte(body, 8'(cs_len >> 8));
      put_byte(body, 8'(cs_len));
      repeat (cs_len) put_byte(body, 8'($urandom));
      ln = $urandom_range(2);
      put_byte(body, 8'(ln));
      repeat (ln) put_byte(body, 8'($urandom));
    end else begin
      put_byte(body, 8'($urandom));
      put_byte(body, 8'($urandom));
      put_byte(body, 8'($urandom));
    end
    if (sni_len >= 0) begin
      el = sni_len + 5;
      put_byte(ext, 8'(EXT_SNI >> 8)); put_byte(ext, 8'(EXT_SNI));
      put_byte(ext, 8'(el >> 8)); put_byte(ext, 8'(el));
      put_byte(ext, 8'((el - 2) >> 8)); put_byte(ext, 8'(el - 2));
      put_byte(ext, 8'd0);
      put_byte(ext, 8'(sni_len >> 8)); put_byte(ext, 8'(sni_len));
      repeat (sni_len) put_byte(ext, 8'($urandom_range(97, 122)));
    end
    if (alpn_n > 0) begin
      logic [7:0] al[$];
      for (int p = 0; p < alpn_n; p++) begin
        pl = $urandom_range(3);
        put_byte(al, 8'(pl));
        repeat (pl) put_byte(al, 8'($urandom));
      end
      el = al.size() + 2;
      put_byte(ext, 8'(EXT_ALPN >> 8)); put_byte(ext, 8'(EXT_ALPN));
      put_byte(ext, 8'(el >> 8)); put_byte(ext, 8'(el));
      put_byte(ext, 8'(al.size() >> 8)); put_byte(ext, 8'(al.size()));
      foreach (al[i]) put_byte(ext, al[i]);
    end
    if (sv_n > 0) begin
      el = client ? 2 * sv_n + 1 : 2;
      put_byte(ext, 8'(EXT_SV >> 8)); put_byte(ext, 8'(EXT_SV));
      put_byte(ext, 8'(el >> 8)); put_byte(ext, 8'(el));
      if (client) put_byte(ext, 8'(2 * sv_n));
      repeat (client ? 2 * sv_n : 2) put_byte(ext, 8'($urandom));
    end
    if ($urandom_range(3) == 0) begin
      // some unknown extension
      put_byte(ext, 8'($urandom_range(1, 255))); put_byte(ext, 8'($urandom));
      put_byte(ext, 8'd0); put_byte(ext, 8'd1); put_byte(ext, 8'($urandom));
    end
    ln = ext.size() + (bad_len ? $urandom_range(1, 9) : 0);
    put_byte(body, 8'(ln >> 8));
    put_byte(body, 8'(ln));
    foreach (ext[i]) put_byte(body, ext[i]);
    put_byte(q, CT_HANDSHAKE);
    put_byte(q, 8'h03);
    put_byte(q, 8'($urandom_range(4)));
    put_byte(q, 8'(body.size() >> 8));
    put_byte(q, 8'(body.size()));
    foreach (body[i]) put_byte(q, body[i]);
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // checker: compares every result transfer with the oldest expectation
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_ch.data);
        end else begin
          exp_r = results_due.pop_front();
          if (out_ch.data.kind !== exp_r.kind || out_ch.data.value !== exp_r.value ||
              out_ch.data.extra !== exp_r.extra ||
              out_ch.data.content_type !== exp_r.content_type ||
              out_ch.data.last !== exp_r.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", exp_r, out_ch.data);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // directed: empty records, non-handshake, a non-hello handshake, truncation, extremes
  task automatic test_directed();
    logic [7:0] q[$];
    q = '{8'd23, 8'h03, 8'h03, 8'h00, 8'h00};
    send_buf(q, 1'b0);
    q = '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h02, 8'hFF, 8'h00};
    send_buf(q, 1'b0);
    q = '{8'd22, 8'h03, 8'h01, 8'h00, 8'h01, 8'd5};
    send_buf(q, 1'b0);
    q = '{8'd22, 8'h03};
    send_buf(q, 1'b1);
    q = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hAA};
    send_buf(q, 1'b1);
    records_sent += 5;
  endtask

  task automatic test_client_hello();
    logic [7:0] q[$];
    q.delete();
    build_hello(q, 1'b1, 2, 1'b1, 3, 2, 3, 1'b0);
    send_buf(q, 1'b0);
    records_sent++;
  endtask

  task automatic test_server_hello();
    logic [7:0] q[$];
    q.delete();
    build_hello(q, 1'b0, 0, 1'b0, -1, 1, 1, 1'b0);
    send_buf(q, 1'b0);
    records_sent++;
  endtask

  task automatic test_random(int n_bytes);
    logic [7:0] q[$];
    int stop, sel;
    stop = bytes_sent + n_bytes;
    while (bytes_sent < stop) begin
      q.delete();
      sel = $urandom_range(9);
      if (sel < 7) begin
        build_hello(q, $urandom_range(2) != 0, $urandom_range(3), $urandom_range(1),
                    int'($urandom_range(5)) - 1, $urandom_range(2), $urandom_range(3),
                    $urandom_range(5) == 0);
        if (sel == 6) begin
          // flip a random byte to reach the bounds checks
          q[$urandom_range(q.size() - 1)] = 8'($urandom);
        end
      end else begin
        put_byte(q, 8'($urandom));
        put_byte(q, 8'($urandom)); put_byte(q, 8'($urandom));
        put_byte(q, 8'd0); put_byte(q, 8'($urandom_range(6)));
        repeat (q[4]) put_byte(q, 8'($urandom));
      end
      if ($urandom_range(7) == 0) begin
        q = q[0:$urandom_range(q.size() - 1)];
        send_buf(q, 1'b1);
      end else send_buf(q, 1'b0);
      records_sent++;
    end
  endtask

  initial begin
    ph = P_H0;
    rec_type = 0; hbyte = 0; proto_idx = 0; is_client = 0;
    rec_ver = 0; rec_len = 0; rec_seen = 0; fcnt = 0; flen = 0; ext_end = 0;
    ext_type = 0; ext_len = 0; icnt = 0; best_ver = 0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 35;
    recv_idle_pct = 46;
    test_directed();
    test_client_hello();
    // hold the sender until every queued result has drained
    wait_drained();
    send_idle_pct = 46;
    recv_idle_pct = 35;
    test_server_hello();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(60);
    wait_drained();
    $display("covered %0d records in %0d bytes, %0d results checked",
             records_sent, bytes_sent, results_seen);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout");
    $display("Regression FAIL");
    $finish;
  end

endmodule

### sim.f
rtl/thfe_pkg.sv
rtl/thfe_if.sv
rtl/thfe_out_queue.sv
rtl/tls_hello_field_extractor_unit.sv
bench/tls_hello_field_extractor_unit_tb.sv
